@@ rtl/core/bcc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcc_pkg
// Shared types and constants of the button click classifier.
// ----------------------------------------------------------------------------
package bcc_pkg;

	localparam int TIME_W    = 32;
	localparam int WIN_W     = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 16;

	typedef enum logic [2:0] {
		EV_NONE    = 3'd0,
		EV_PRESS   = 3'd1,
		EV_RELEASE = 3'd2,
		EV_SHORT   = 3'd3,
		EV_LONG    = 3'd4,
		EV_DOUBLE  = 3'd5
	} bcc_event_t;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_LOW_PRESSED     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TIME   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MIN_TIME  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MAX_TIME  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_TIME       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_GAP_TIME = 3'd5;

	// request codes
	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_TAKE   = 1'b1;

	typedef struct packed {
		logic             low_pressed;
		logic [WIN_W-1:0] debounce_time;
		logic [WIN_W-1:0] short_min_time;
		logic [WIN_W-1:0] short_max_time;
		logic [WIN_W-1:0] long_time;
		logic [WIN_W-1:0] double_gap_time;
	} bcc_cfg_t;

	typedef struct packed {
		logic              raw_seen;
		logic [TIME_W-1:0] last_change_at;
		logic              pressed_now;
		logic [TIME_W-1:0] press_start_at;
		logic              long_done;
		logic              double_pending;
		logic [TIME_W-1:0] first_release_at;
		bcc_event_t        latched_event;
	} bcc_state_t;

endpackage

@@ rtl/core/bcc_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcc_in_if / bcc_out_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface bcc_in_if;
	logic                      valid;
	logic                      ready;
	logic                      req_type;
	logic                      raw_level;
	logic [bcc_pkg::TIME_W-1:0] now_time;

	modport source (output valid, output req_type, output raw_level, output now_time,
		input ready);
	modport sink (input valid, input req_type, input raw_level, input now_time,
		output ready);
endinterface

interface bcc_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] event_code;
	logic       is_pressed;

	modport source (output valid, output event_code, output is_pressed, input ready);
	modport sink (input valid, input event_code, input is_pressed, output ready);
endinterface

@@ rtl/core/button_click_classifier_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_click_classifier_unit
// Debounces one button pin and classifies press, release, short, long and
// double clicks; the newest event stays latched until a take request.
// ----------------------------------------------------------------------------
//
//  channel  | dir | transfer payload
//  ---------+-----+------------------------------------------------
//  in_ch    | in  | req_type, raw_level, now_time
//  out_ch   | out | event_code, is_pressed (one per request)
//  cfg_*    | in  | cfg_index, cfg_data, write on cfg_we
//
//  One request per cycle sustained while out_ch is ready; a request moves
//  from the input register into the result register, which drives out_ch.
//  The classifier state updates as a request moves from the input register
//  into the result register, so back-to-back requests see each other.
//  A stall on out_ch holds both registers; in_ch.ready drops only when both
//  are full. Reset clears state and sets the default timings.
//
module button_click_classifier_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [bcc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bcc_pkg::CFG_DAT_W-1:0]   cfg_data,
	bcc_in_if.sink                          in_ch,
	bcc_out_if.source                       out_ch
);
	import bcc_pkg::*;

	bcc_cfg_t          cfg;
	bcc_state_t        state_q;
	bcc_state_t        state_next;

	// input stage
	logic              valid_s1;
	logic              req_type_s1;
	logic              raw_level_s1;
	logic [TIME_W-1:0] now_time_s1;

	// result stage
	logic              out_valid_q;
	logic [2:0]        event_code_q;
	logic              is_pressed_q;

	logic [2:0]        step_code;
	logic              step_pressed;
	logic              advance;

	bcc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bcc_step u_step (
		.cfg        (cfg),
		.state      (state_q),
		.req_type   (req_type_s1),
		.raw_level  (raw_level_s1),
		.now_time   (now_time_s1),
		.state_next (state_next),
		.event_code (step_code),
		.is_pressed (step_pressed)
	);

	// request leaves the input register when the result slot is free
	assign advance     = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			req_type_s1  <= in_ch.req_type;
			raw_level_s1 <= in_ch.raw_level;
			now_time_s1  <= in_ch.now_time;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= state_next;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			event_code_q <= step_code;
			is_pressed_q <= step_pressed;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.event_code = event_code_q;
	assign out_ch.is_pressed = is_pressed_q;

endmodule

@@ rtl/core/bcc_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcc_cfg_regs
// Configuration register file, write only, reset to the default timings.
// ----------------------------------------------------------------------------
module bcc_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [bcc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bcc_pkg::CFG_DAT_W-1:0]   cfg_data,
	output bcc_pkg::bcc_cfg_t               cfg
);
	import bcc_pkg::*;

	bcc_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low_pressed     <= 1'b1;
			cfg_q.debounce_time   <= 16'd20;
			cfg_q.short_min_time  <= 16'd30;
			cfg_q.short_max_time  <= 16'd400;
			cfg_q.long_time       <= 16'd800;
			cfg_q.double_gap_time <= 16'd300;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LOW_PRESSED:     cfg_q.low_pressed     <= cfg_data[0];
				CFG_DEBOUNCE_TIME:   cfg_q.debounce_time   <= cfg_data;
				CFG_SHORT_MIN_TIME:  cfg_q.short_min_time  <= cfg_data;
				CFG_SHORT_MAX_TIME:  cfg_q.short_max_time  <= cfg_data;
				CFG_LONG_TIME:       cfg_q.long_time       <= cfg_data;
				CFG_DOUBLE_GAP_TIME: cfg_q.double_gap_time <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/core/bcc_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcc_step
// Next-state and result logic for one request: debounce, press/release
// confirmation and click classification.
// ----------------------------------------------------------------------------
module bcc_step (
	input  bcc_pkg::bcc_cfg_t            cfg,
	input  bcc_pkg::bcc_state_t          state,
	input  logic                         req_type,
	input  logic                         raw_level,
	input  logic [bcc_pkg::TIME_W-1:0]   now_time,
	output bcc_pkg::bcc_state_t          state_next,
	output logic [2:0]                   event_code,
	output logic                         is_pressed
);
	import bcc_pkg::*;

	logic              act;
	logic [TIME_W-1:0] since_change;
	logic [TIME_W-1:0] held;
	logic [TIME_W-1:0] since_press;
	logic [TIME_W-1:0] since_first;
	bcc_state_t        s;
	bcc_event_t        code;

	always_comb begin
		s            = state;
		code         = EV_NONE;
		act          = cfg.low_pressed ? ~raw_level : raw_level;
		since_change = '0;
		held         = '0;
		since_press  = '0;
		since_first  = '0;

		if (req_type == REQ_TAKE) begin
			code            = state.latched_event;
			s.latched_event = EV_NONE;
		end else begin
			if (act != state.raw_seen) begin
				s.raw_seen       = act;
				s.last_change_at = now_time;
			end
			since_change = now_time - s.last_change_at;

			// still bouncing: only the raw tracker moves
			if (since_change >= {{(TIME_W-WIN_W){1'b0}}, cfg.debounce_time}) begin
				held = now_time - state.press_start_at;
				if (s.raw_seen != state.pressed_now) begin
					if (s.raw_seen) begin
						s.pressed_now    = 1'b1;
						s.press_start_at = now_time;
						s.long_done      = 1'b0;
						s.latched_event  = EV_PRESS;
					end else begin
						s.pressed_now   = 1'b0;
						s.latched_event = EV_RELEASE;
						since_first     = now_time - state.first_release_at;
						if (state.long_done) begin
							s.long_done = 1'b0;
						end else if (held < {{(TIME_W-WIN_W){1'b0}}, cfg.short_min_time}) begin
							// noise, release stays latched
						end else if (held <= {{(TIME_W-WIN_W){1'b0}}, cfg.short_max_time}) begin
							if (state.double_pending &&
								since_first < {{(TIME_W-WIN_W){1'b0}}, cfg.double_gap_time}) begin
								s.latched_event  = EV_DOUBLE;
								s.double_pending = 1'b0;
							end else begin
								s.double_pending   = 1'b1;
								s.first_release_at = now_time;
								s.latched_event    = EV_NONE;
							end
						end else begin
							s.latched_event = EV_LONG;
						end
					end
				end

				// hold past the long limit
				since_press = now_time - s.press_start_at;
				if (s.pressed_now && !s.long_done &&
					since_press >= {{(TIME_W-WIN_W){1'b0}}, cfg.long_time}) begin
					s.latched_event  = EV_LONG;
					s.long_done      = 1'b1;
					s.double_pending = 1'b0;
				end

				// double-click window ran out: single short click
				since_first = now_time - s.first_release_at;
				if (s.double_pending && !s.pressed_now &&
					since_first >= {{(TIME_W-WIN_W){1'b0}}, cfg.double_gap_time}) begin
					s.latched_event  = EV_SHORT;
					s.double_pending = 1'b0;
				end
			end
		end
	end

	assign state_next = s;
	assign event_code = code;
	assign is_pressed = s.pressed_now;

endmodule
